// ----- design/mkts_pkg.sv -----
// package for the multi-keyword text search block
// types, field structs and sequencer states; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mkts_pkg;

  localparam logic FUNC_KEY  = 1'b0;
  localparam logic FUNC_TEXT = 1'b1;

  typedef struct packed {
    logic       func;
    logic [3:0] key_index;
    logic [3:0] key_pos;
    logic [7:0] byte_value;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  keyword_number;
    logic [15:0] match_position;
  } out_item_t;

  // text buffer control from the sequencer
  typedef struct packed {
    logic       push;
    logic       clear;
    logic [7:0] data;
  } txt_ctrl_t;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_START   = 7'b0000010,
    ST_ENDINIT = 7'b0000100,
    ST_KEY     = 7'b0001000,
    ST_CMP     = 7'b0010000,
    ST_NEXTS   = 7'b0100000,
    ST_EMIT    = 7'b1000000
  } state_t;

endpackage
`default_nettype wire

// ----- design/mkts_ram.sv -----
// generic single-port-write, registered-read ram
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module mkts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 108,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- design/mkts_text_buf.sv -----
// circular window of the newest text bytes with byte count and write pointer
// depends on mkts_pkg
`timescale 1ns / 1ps
`default_nettype none
module mkts_text_buf #(
  parameter int MAX_KEY_LEN  = 12,
  parameter int MAX_TEXT_LEN = 65536,
  parameter int PW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1,
  parameter int CW = $clog2(MAX_TEXT_LEN + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mkts_pkg::txt_ctrl_t ctrl,
  input  wire logic [PW-1:0]     rd_ptr,
  output logic      [7:0]        rd_data,
  output logic      [CW-1:0]     count,
  output logic      [PW-1:0]     wptr
);
  logic [7:0]    win_r [MAX_KEY_LEN];
  logic [CW-1:0] count_r;
  logic [PW-1:0] wptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      wptr_r  <= '0;
    end else if (ctrl.clear) begin
      count_r <= '0;
      wptr_r  <= '0;
    end else if (ctrl.push) begin
      count_r <= count_r + CW'(1);
      wptr_r  <= (wptr_r == PW'(MAX_KEY_LEN - 1)) ? '0 : wptr_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push && !ctrl.clear) begin
      win_r[wptr_r] <= ctrl.data;
    end
  end

  assign rd_data = win_r[rd_ptr];
  assign count   = count_r;
  assign wptr    = wptr_r;
endmodule
`default_nettype wire

// ----- design/multi_keyword_text_search_top.sv -----
// multi-keyword text search: keyword table, text window and compare sequencer
// depends on mkts_pkg, mkts_ram, mkts_text_buf
//
// channel  dir  handshake             payload
// in       in   in_valid / in_ready   mkts_pkg::in_item_t
// out      out  out_valid / out_ready mkts_pkg::out_item_t
//
// a keyword byte is written without leaving the idle state. a text byte passes
// the start state, then, for each start offset checked, the key state once per
// keyword and the compare state once per compared byte, as there is a single
// byte comparator and the keyword ram has one read port. the end of text checks
// up to MAX_KEY_LEN-1 more offsets. reset is synchronous and clears lengths and
// the text state. a stalled result holds the block in its emit state.
`timescale 1ns / 1ps
`default_nettype none
module multi_keyword_text_search_top #(
  parameter int NUM_KEYWORDS = 9,
  parameter int MAX_KEY_LEN  = 12,
  parameter int MAX_TEXT_LEN = 65536
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire mkts_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mkts_pkg::out_item_t      out_data
);
  localparam int DEPTH = NUM_KEYWORDS * MAX_KEY_LEN;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KW = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;
  localparam int PW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int LW = $clog2(MAX_KEY_LEN + 1);
  localparam int CW = $clog2(MAX_TEXT_LEN + 1);

  mkts_pkg::state_t state_r, state_nxt;
  logic [LW-1:0] len_r [NUM_KEYWORDS];
  logic          done_r, done_nxt;
  logic          last_r, last_nxt;
  logic          pushed_r, pushed_nxt;
  logic          end_mode_r, end_mode_nxt;
  logic [CW-1:0] s_r, s_nxt;
  logic [PW-1:0] sptr_r, sptr_nxt;
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [LW-1:0] j_r, j_nxt;
  logic          hit_r, hit_nxt;
  logic          out_valid_r;
  mkts_pkg::out_item_t out_data_r;

  mkts_pkg::txt_ctrl_t tctrl;
  logic [7:0]    win_byte, key_byte;
  logic [CW-1:0] count;
  logic [PW-1:0] wptr;

  logic          accept, key_wr, out_free;
  logic [AW-1:0] waddr, raddr;
  logic [LW-1:0] cur_len, j_sel;
  logic          skip_key;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == mkts_pkg::ST_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign key_wr   = accept && (in_data.func == mkts_pkg::FUNC_KEY)
                    && (32'(in_data.key_index) < NUM_KEYWORDS)
                    && (32'(in_data.key_pos) < MAX_KEY_LEN);
  assign waddr    = AW'(32'(in_data.key_index) * MAX_KEY_LEN + 32'(in_data.key_pos));
  assign j_sel    = (state_r == mkts_pkg::ST_CMP) ? j_r + LW'(1) : '0;
  assign raddr    = AW'(32'(k_r) * MAX_KEY_LEN + 32'(j_sel));
  assign cur_len  = len_r[k_r];
  assign skip_key = (cur_len == '0) ||
                    (({1'b0, s_r} + (CW+1)'(cur_len)) > {1'b0, count});

  mkts_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_wr),
    .waddr (waddr),
    .wdata (in_data.byte_value),
    .raddr (raddr),
    .rdata (key_byte)
  );

  mkts_text_buf #(.MAX_KEY_LEN(MAX_KEY_LEN), .MAX_TEXT_LEN(MAX_TEXT_LEN)) u_text (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (tctrl),
    .rd_ptr  (ptr_r),
    .rd_data (win_byte),
    .count   (count),
    .wptr    (wptr)
  );

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    wrap_inc = (p == PW'(MAX_KEY_LEN - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    state_nxt    = state_r;
    done_nxt     = done_r;
    last_nxt     = last_r;
    pushed_nxt   = pushed_r;
    end_mode_nxt = end_mode_r;
    s_nxt        = s_r;
    sptr_nxt     = sptr_r;
    ptr_nxt      = ptr_r;
    k_nxt        = k_r;
    j_nxt        = j_r;
    hit_nxt      = hit_r;
    tctrl.push   = 1'b0;
    tctrl.clear  = 1'b0;
    tctrl.data   = in_data.byte_value;
    case (state_r)
      mkts_pkg::ST_IDLE: begin
        if (accept && (in_data.func == mkts_pkg::FUNC_TEXT)) begin
          last_nxt = in_data.last;
          if (done_r) begin
            if (in_data.last) begin
              tctrl.clear = 1'b1;
              done_nxt    = 1'b0;
            end
          end else begin
            pushed_nxt = (32'(count) < MAX_TEXT_LEN);
            tctrl.push = (32'(count) < MAX_TEXT_LEN);
            state_nxt  = mkts_pkg::ST_START;
          end
        end
      end
      mkts_pkg::ST_START: begin
        k_nxt = '0;
        if (pushed_r && (32'(count) >= MAX_KEY_LEN)) begin
          s_nxt        = CW'(32'(count) - MAX_KEY_LEN);
          sptr_nxt     = wptr;
          end_mode_nxt = 1'b0;
          state_nxt    = mkts_pkg::ST_KEY;
        end else if (last_r) begin
          state_nxt = mkts_pkg::ST_ENDINIT;
        end else begin
          state_nxt = mkts_pkg::ST_IDLE;
        end
      end
      mkts_pkg::ST_ENDINIT: begin
        k_nxt        = '0;
        end_mode_nxt = 1'b1;
        if (32'(count) >= MAX_KEY_LEN) begin
          s_nxt    = CW'(32'(count) - MAX_KEY_LEN + 1);
          sptr_nxt = wrap_inc(wptr);
        end else begin
          s_nxt    = '0;
          sptr_nxt = '0;
        end
        if (32'(s_nxt) < 32'(count)) begin
          state_nxt = mkts_pkg::ST_KEY;
        end else begin
          hit_nxt   = 1'b0;
          state_nxt = mkts_pkg::ST_EMIT;
        end
      end
      mkts_pkg::ST_KEY: begin
        j_nxt   = '0;
        ptr_nxt = sptr_r;
        if (!skip_key) begin
          state_nxt = mkts_pkg::ST_CMP;
        end else if (32'(k_r) == NUM_KEYWORDS - 1) begin
          state_nxt = mkts_pkg::ST_NEXTS;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      mkts_pkg::ST_CMP: begin
        if (win_byte == key_byte) begin
          if (j_r + LW'(1) == cur_len) begin
            hit_nxt   = 1'b1;
            state_nxt = mkts_pkg::ST_EMIT;
          end else begin
            j_nxt   = j_r + LW'(1);
            ptr_nxt = wrap_inc(ptr_r);
          end
        end else if (32'(k_r) == NUM_KEYWORDS - 1) begin
          state_nxt = mkts_pkg::ST_NEXTS;
        end else begin
          k_nxt     = k_r + KW'(1);
          state_nxt = mkts_pkg::ST_KEY;
        end
      end
      mkts_pkg::ST_NEXTS: begin
        k_nxt = '0;
        if (!end_mode_r) begin
          state_nxt = last_r ? mkts_pkg::ST_ENDINIT : mkts_pkg::ST_IDLE;
        end else if (({1'b0, s_r} + (CW+1)'(1)) < {1'b0, count}) begin
          s_nxt     = s_r + CW'(1);
          sptr_nxt  = wrap_inc(sptr_r);
          state_nxt = mkts_pkg::ST_KEY;
        end else begin
          hit_nxt   = 1'b0;
          state_nxt = mkts_pkg::ST_EMIT;
        end
      end
      mkts_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = mkts_pkg::ST_IDLE;
          // a match before the end of text holds off the rest of the text
          if (end_mode_r || last_r) begin
            tctrl.clear = 1'b1;
            done_nxt    = 1'b0;
          end else begin
            done_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = mkts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mkts_pkg::ST_IDLE;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_KEYWORDS; i++) begin
        len_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      if (key_wr && in_data.last) begin
        len_r[KW'(in_data.key_index)] <= LW'(in_data.key_pos) + LW'(1);
      end
      if (state_r == mkts_pkg::ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    pushed_r   <= pushed_nxt;
    end_mode_r <= end_mode_nxt;
    s_r        <= s_nxt;
    sptr_r     <= sptr_nxt;
    ptr_r      <= ptr_nxt;
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    hit_r      <= hit_nxt;
    if (state_r == mkts_pkg::ST_EMIT && out_free) begin
      out_data_r.found          <= hit_r;
      out_data_r.keyword_number <= hit_r ? 4'(k_r) : 4'd0;
      out_data_r.match_position <= hit_r ? 16'(s_r) : 16'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cmp_in_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mkts_pkg::ST_CMP) |-> (j_r < cur_len))
    else $error("compare index past keyword length");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count) <= MAX_TEXT_LEN)
    else $error("text count beyond limit");

  a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mkts_pkg::ST_EMIT && out_free && end_mode_r) |=> (count == '0))
    else $error("text state not cleared after end of text");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (state_r == mkts_pkg::ST_IDLE || state_r == mkts_pkg::ST_EMIT
                || $past(state_r) == mkts_pkg::ST_EMIT))
    else $error("search running after a reported match");
endmodule
`default_nettype wire

// ----- tb/mkts_checker.sv -----
// checker for the multi-keyword text search block: predicts each search result
// from accepted transactions and compares them with the result channel; uses mkts_pkg
`timescale 1ns / 1ps
module mkts_checker #(
  parameter int NKEY = 9,
  parameter int KLEN = 12,
  parameter int TLEN = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  mkts_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  mkts_pkg::out_item_t out_data,
  output int                  pending,
  output int                  fail_count
);

  logic [7:0] key_table [NKEY][KLEN];
  int         key_len [NKEY];
  logic [7:0] window [KLEN];
  int         text_count;
  bit         match_done;
  mkts_pkg::out_item_t expected_hits[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report(input string what, input int got, input int exp);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, exp);
    fail_count++;
  endtask

  function automatic void clear_text();
    foreach (window[i]) window[i] = '0;
    text_count = 0;
    match_done = 0;
  endfunction

  // lowest keyword wholly present at offset s, -1 if none
  function automatic int keyword_at(input int s);
    bit ok;
    for (int k = 0; k < NKEY; k++) begin
      if (key_len[k] == 0 || s + key_len[k] > text_count) continue;
      ok = 1;
      for (int j = 0; j < key_len[k]; j++)
        if (window[(s + j) % KLEN] != key_table[k][j]) ok = 0;
      if (ok) return k;
    end
    return -1;
  endfunction

  function automatic mkts_pkg::out_item_t hit(input int k, input int s);
    mkts_pkg::out_item_t r;
    r.found = (k >= 0);
    r.keyword_number = (k >= 0) ? 4'(k) : 4'd0;
    r.match_position = (k >= 0) ? 16'(s) : 16'd0;
    return r;
  endfunction

  function automatic void search_step(input mkts_pkg::in_item_t it);
    int k, s, first;
    if (it.func == mkts_pkg::FUNC_KEY) begin
      if (it.key_index < NKEY && it.key_pos < KLEN) begin
        key_table[it.key_index][it.key_pos] = it.byte_value;
        if (it.last) key_len[it.key_index] = it.key_pos + 1;
      end
      return;
    end
    if (match_done) begin
      if (it.last) clear_text();
      return;
    end
    if (text_count < TLEN) begin
      window[text_count % KLEN] = it.byte_value;
      text_count++;
      if (text_count >= KLEN) begin
        s = text_count - KLEN;
        k = keyword_at(s);
        if (k >= 0) begin
          if (it.last) clear_text();
          else match_done = 1;
          expected_hits.push_back(hit(k, s));
          return;
        end
      end
    end
    if (!it.last) return;
    first = (text_count >= KLEN) ? text_count - KLEN + 1 : 0;
    for (s = first; s < text_count; s++) begin
      k = keyword_at(s);
      if (k >= 0) begin
        clear_text();
        expected_hits.push_back(hit(k, s));
        return;
      end
    end
    clear_text();
    expected_hits.push_back(hit(-1, 0));
  endfunction

  always @(posedge clk) begin
    mkts_pkg::out_item_t e;
    if (!rst_n) begin
      foreach (key_len[k]) key_len[k] = 0;
      foreach (key_table[k, j]) key_table[k][j] = '0;
      clear_text();
      expected_hits.delete();
    end else begin
      if (in_valid && in_ready) search_step(in_data);
      if (out_valid && out_ready) begin
        if (expected_hits.size() == 0) begin
          report("unexpected transaction, found", out_data.found, -1);
        end else begin
          e = expected_hits.pop_front();
          if (out_data.found !== e.found) report("found", out_data.found, e.found);
          if (out_data.keyword_number !== e.keyword_number)
            report("keyword_number", out_data.keyword_number, e.keyword_number);
          if (out_data.match_position !== e.match_position)
            report("match_position", out_data.match_position, e.match_position);
        end
      end
    end
    pending = expected_hits.size();
  end

endmodule

// ----- tb/testbench.sv -----
// top of the multi-keyword text search testbench: clock, reset, stimulus, verdict
// depends on mkts_pkg, multi_keyword_text_search_top and mkts_checker
`timescale 1ns / 1ps
module testbench;

  localparam int NKEY = 9;
  localparam int KLEN = 12;
  localparam int ITEMS = 1750;
  localparam int IDLE_LIMIT = 30000;
  localparam int DRAIN_CYCLES = 1500;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  mkts_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  mkts_pkg::out_item_t out_data;
  int                  pending, fail_count;

  // shadow of what has been loaded, so lengths never cover unwritten bytes
  bit         written [16][16];
  logic [7:0] key_copy [NKEY][KLEN];
  int         key_len [NKEY];
  int         sent = 0;
  int         burst_left = 0;
  int         idle_cycles = 0;
  int         stall_mode = 0;
  int         mode_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  multi_keyword_text_search_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  mkts_checker #(.NKEY(NKEY), .KLEN(KLEN)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .pending(pending), .fail_count(fail_count)
  );

  // receiver stall pattern: always ready, coin flip, or mostly stalled
  always @(posedge clk) begin
    if (mode_cycles == 0) begin
      stall_mode <= $urandom_range(2);
      mode_cycles <= $urandom_range(200, 20);
    end else begin
      mode_cycles <= mode_cycles - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(1);
      default: out_ready <= ($urandom_range(3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_item(input mkts_pkg::in_item_t it);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? 200 : $urandom_range(30, 1);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  function automatic bit prefix_written(input int idx, input int pos);
    for (int j = 0; j <= pos; j++)
      if (!written[idx][j]) return 0;
    return 1;
  endfunction

  function automatic logic [7:0] rand_byte(input int alpha);
    if (alpha == 0) return 8'($urandom_range(8'h62, 8'h61));
    if (alpha == 1) return 8'($urandom_range(8'h64, 8'h61));
    return 8'($urandom_range(255));
  endfunction

  task automatic load_byte(input int idx, input int pos, input logic [7:0] b, input bit lst);
    mkts_pkg::in_item_t it;
    it = '0;
    it.func = mkts_pkg::FUNC_KEY;
    it.key_index = 4'(idx);
    it.key_pos = 4'(pos);
    it.byte_value = b;
    if (idx < NKEY && pos < KLEN) begin
      written[idx][pos] = 1;
      key_copy[idx][pos] = b;
      it.last = lst && prefix_written(idx, pos);
      if (it.last) key_len[idx] = pos + 1;
    end else begin
      it.last = lst;
    end
    push_item(it);
  endtask

  task automatic text_byte(input logic [7:0] b, input bit lst);
    mkts_pkg::in_item_t it;
    it = '0;
    it.func = mkts_pkg::FUNC_TEXT;
    it.byte_value = b;
    it.last = lst;
    it.key_index = 4'($urandom_range(15));
    it.key_pos = 4'($urandom_range(15));
    push_item(it);
  endtask

  task automatic load_keyword(input int idx, input int len, input int alpha);
    for (int j = 0; j < len; j++)
      load_byte(idx, j, rand_byte(alpha), j == len - 1);
  endtask

  // a text of random bytes, often with a copy of some loaded keyword inside
  task automatic random_text();
    int n, at, k, alpha;
    logic [7:0] txt[$];
    n = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(24, 1);
    alpha = $urandom_range(2);
    for (int i = 0; i < n; i++) txt.push_back(rand_byte(alpha));
    if ($urandom_range(3) != 0) begin
      k = $urandom_range(NKEY - 1);
      if (key_len[k] > 0) begin
        at = $urandom_range(n);
        for (int j = key_len[k] - 1; j >= 0; j--) txt.insert(at, key_copy[k][j]);
      end
    end
    foreach (txt[i]) text_byte(txt[i], i == txt.size() - 1);
  endtask

  initial begin
    string cake;
    cake = "cake";
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: short keyword, full-length keyword, ignored loads, edge bytes
    for (int j = 0; j < 4; j++) load_byte(0, j, cake[j], j == 3);
    for (int j = 0; j < KLEN; j++) load_byte(8, j, (j % 2) ? 8'hff : 8'h00, j == KLEN - 1);
    load_byte(9, 0, 8'h5a, 1'b1);
    load_byte(15, 15, 8'hff, 1'b1);
    load_byte(3, 12, 8'h11, 1'b0);
    text_byte(8'h78, 1'b0);
    for (int j = 0; j < 4; j++) text_byte(cake[j], 1'b0);
    text_byte(8'h63, 1'b1);
    text_byte(8'h00, 1'b1);
    text_byte(8'h63, 1'b0);
    text_byte(8'hff, 1'b1);

    while (sent < ITEMS) begin
      case ($urandom_range(19))
        0, 1: load_keyword($urandom_range(NKEY - 1),
                           ($urandom_range(3) == 0) ? KLEN : $urandom_range(4, 1),
                           $urandom_range(2));
        2: load_byte($urandom_range(15), $urandom_range(15), rand_byte(2), $urandom_range(1));
        default: random_text();
      endcase
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
